>>> src/tprt_pkg.sv
// Shared types, codes and constants for the touchpad relative motion and tap block.
package tprt_pkg;

    // Request codes on req_type
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_MOVE  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    // Action codes on the result channel
    localparam logic [1:0] ACT_MOVE = 2'd0;
    localparam logic [1:0] ACT_DOWN = 2'd1;
    localparam logic [1:0] ACT_UP   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_INV_SCALE    = 2'd0;
    localparam logic [1:0] CFG_DENSITY      = 2'd1;
    localparam logic [1:0] CFG_TAP_MAX_TIME = 2'd2;

    // Configuration reset values
    localparam logic [15:0] INV_SCALE_RST    = 16'd256;
    localparam logic [15:0] DENSITY_RST      = 16'd256;
    localparam logic [23:0] TAP_MAX_TIME_RST = 24'd300000;

    // Field widths fixed by the interface
    localparam int POS_W    = 16;
    localparam int TIME_W   = 40;
    localparam int DELTA_W  = 16;
    localparam int TRAVEL_W = 24;
    localparam int CFG_W    = 24;

    // Operand pair routed to the shared multiplier
    typedef enum logic [1:0] {
        MUL_XX,
        MUL_YY,
        MUL_XS,
        MUL_YS
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XS,
        ST_MUL_YS,
        ST_WY,
        ST_ROOT,
        ST_COMMIT,
        ST_TEST,
        ST_EMIT_MOVE,
        ST_EMIT_DOWN,
        ST_EMIT_UP
    } tprt_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_req;
        logic       begin_slide;
        mul_sel_t   mul_sel;
        logic       prod_load;
        logic       sum_first;
        logic       sum_add;
        logic       root_start;
        logic       wx_load;
        logic       wy_load;
        logic       commit;
        logic       test;
        logic       emit;
        logic [1:0] emit_action;
        logic       emit_last;
    } tprt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       slide_on;
        logic       root_done;
        logic       move_nz;
        logic       tap_ok;
        logic       out_free;
    } tprt_sts_t;

endpackage

>>> src/touchpad_relative_motion_tap_core.sv
// Top level: touchpad relative motion with tap to click.
//
// Request channel (req_valid / req_stall) takes one touch beat: begin, move or end
// with a position and a timestamp. Result channel (rsp_valid / rsp_stall) gives
// zero to three beats per request: a relative move when a whole pixel delta shows
// up, then button down and button up when an end closes a short, still touch.
// The last beat of a request carries last; the first beat of a slide carries
// gesture_start.
// One request is in work at a time. A begin is accepted, decoded and then the block
// is idle again. A move or end makes four passes through the shared multiplier, then
// the bit-serial square root (17 iterations, one root bit per cycle) for the step
// length, then commit, tap test and the result beats; the move slot is passed even
// with no move. A result waiting in the output register does not block the next
// request; a stalled receiver holds the beat and, once a second beat is due, holds
// the controller until the register frees, adding those stall cycles.
// Reset clears the slide and loads the configuration defaults; configuration is
// written with cfg_we / cfg_index / cfg_data, and the user must write it only while
// the block is idle; the block itself does not enforce this.
module touchpad_relative_motion_tap_core #(
    parameter int POS_FRAC_BITS   = 4,
    parameter int SCALE_FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [tprt_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [1:0]                           req_type,
    input  logic [tprt_pkg::POS_W-1:0]           pos_x,
    input  logic [tprt_pkg::POS_W-1:0]           pos_y,
    input  logic [tprt_pkg::TIME_W-1:0]          time_us,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [1:0]                           action,
    output logic signed [tprt_pkg::DELTA_W-1:0]  delta_x,
    output logic signed [tprt_pkg::DELTA_W-1:0]  delta_y,
    output logic                                 gesture_start,
    output logic [tprt_pkg::TIME_W-1:0]          stamp_us,
    output logic                                 last
);

    import tprt_pkg::*;

    tprt_cmd_t cmd;
    tprt_sts_t sts;

    tprt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tprt_dp #(
        .POS_FRAC_BITS   (POS_FRAC_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .time_us       (time_us),
        .rsp_stall     (rsp_stall),
        .cmd           (cmd),
        .sts           (sts),
        .rsp_valid     (rsp_valid),
        .action        (action),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .gesture_start (gesture_start),
        .stamp_us      (stamp_us),
        .last          (last)
    );

endmodule

>>> src/tprt_isqrt.sv
// Iterative integer square root, one root bit per cycle.
module tprt_isqrt #(
    parameter int RAD_W = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic [RAD_W/2-1:0]   root,
    output logic                 done
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int WORK_W = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [WORK_W-1:0] rem_sh;
    logic [WORK_W-1:0] trial;
    logic              fits;

    // Bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = WORK_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    // Control: count the root bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Data: shift radicand, update remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> src/tprt_ctrl.sv
// Controller state machine: sequences accept, multiply, root, commit, tap test and result beats.
module tprt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tprt_pkg::tprt_sts_t sts,
    output tprt_pkg::tprt_cmd_t cmd
);

    import tprt_pkg::*;

    tprt_state_t state_reg;
    tprt_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_XX;
        cmd.emit_action = ACT_MOVE;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.req_type == REQ_BEGIN)
                begin
                    cmd.begin_slide = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if ((sts.req_type inside {REQ_MOVE, REQ_END}) && sts.slide_on)
                begin
                    state_next = ST_MUL_XX;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_XX:
            begin
                cmd.mul_sel   = MUL_XX;
                cmd.prod_load = 1'b1;
                state_next    = ST_MUL_YY;
            end
            ST_MUL_YY:
            begin
                cmd.mul_sel   = MUL_YY;
                cmd.prod_load = 1'b1;
                cmd.sum_first = 1'b1;
                state_next    = ST_MUL_XS;
            end
            ST_MUL_XS:
            begin
                cmd.mul_sel   = MUL_XS;
                cmd.prod_load = 1'b1;
                cmd.sum_add   = 1'b1;
                state_next    = ST_MUL_YS;
            end
            ST_MUL_YS:
            begin
                cmd.mul_sel    = MUL_YS;
                cmd.prod_load  = 1'b1;
                cmd.wx_load    = 1'b1;
                cmd.root_start = 1'b1;
                state_next     = ST_WY;
            end
            ST_WY:
            begin
                cmd.wy_load = 1'b1;
                state_next  = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sts.root_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = ST_EMIT_MOVE;
            end
            ST_EMIT_MOVE:
            begin
                if (!sts.move_nz)
                begin
                    state_next = sts.tap_ok ? ST_EMIT_DOWN : ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_MOVE;
                    cmd.emit_last   = !sts.tap_ok;
                    state_next      = sts.tap_ok ? ST_EMIT_DOWN : ST_IDLE;
                end
            end
            ST_EMIT_DOWN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_DOWN;
                    state_next      = ST_EMIT_UP;
                end
            end
            ST_EMIT_UP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_action = ACT_UP;
                    cmd.emit_last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

>>> src/tprt_dp.sv
// Datapath: configuration, slide state, shared multiplier, root unit and result register.
module tprt_dp #(
    parameter int POS_FRAC_BITS   = 4,
    parameter int SCALE_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [tprt_pkg::CFG_W-1:0]    cfg_data,
    input  logic [1:0]                    req_type,
    input  logic [tprt_pkg::POS_W-1:0]    pos_x,
    input  logic [tprt_pkg::POS_W-1:0]    pos_y,
    input  logic [tprt_pkg::TIME_W-1:0]   time_us,
    input  logic                          rsp_stall,
    input  tprt_pkg::tprt_cmd_t           cmd,
    output tprt_pkg::tprt_sts_t           sts,
    output logic                          rsp_valid,
    output logic [1:0]                    action,
    output logic signed [tprt_pkg::DELTA_W-1:0] delta_x,
    output logic signed [tprt_pkg::DELTA_W-1:0] delta_y,
    output logic                          gesture_start,
    output logic [tprt_pkg::TIME_W-1:0]   stamp_us,
    output logic                          last
);

    import tprt_pkg::*;

    localparam int FRAC_W  = POS_FRAC_BITS + SCALE_FRAC_BITS;
    localparam int CARRY_W = FRAC_W + 1;
    localparam int STEP_W  = POS_W + 1;
    localparam int MUL_W   = 2 * STEP_W;
    localparam int WX_W    = MUL_W + 1;
    localparam int RAD_W   = MUL_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int CMP_W   = TRAVEL_W + SCALE_FRAC_BITS + POS_FRAC_BITS;
    localparam logic [15:0] UNITY_SCALE = 16'(1 << SCALE_FRAC_BITS);
    localparam logic [WX_W-1:0] FRAC_MASK = {{(WX_W - FRAC_W){1'b0}}, {FRAC_W{1'b1}}};
    localparam logic [CARRY_W-1:0] CARRY_MIN = {1'b1, {FRAC_W{1'b0}}};

    // Configuration
    logic [15:0] inv_scale_reg;
    logic [15:0] density_reg;
    logic [23:0] tap_max_time_reg;

    // Slide state
    logic                      slide_on_reg;
    logic                      start_flag_sent_reg;
    logic [POS_W-1:0]          prev_x_reg;
    logic [POS_W-1:0]          prev_y_reg;
    logic signed [CARRY_W-1:0] carry_x_reg;
    logic signed [CARRY_W-1:0] carry_y_reg;
    logic [TIME_W-1:0]         start_time_reg;
    logic [TRAVEL_W-1:0]       travel_reg;

    // Latched request
    logic [1:0]                req_type_reg;
    logic [POS_W-1:0]          pos_x_reg;
    logic [POS_W-1:0]          pos_y_reg;
    logic [TIME_W-1:0]         time_reg;

    // Work registers
    logic signed [MUL_W-1:0]   prod_reg;
    logic [RAD_W-1:0]          sumsq_reg;
    logic signed [WX_W-1:0]    wx_reg;
    logic signed [WX_W-1:0]    wy_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic                      move_nz_reg;
    logic                      tap_ok_reg;

    // Result register
    logic                      rsp_valid_reg;
    logic [1:0]                action_reg;
    logic signed [DELTA_W-1:0] delta_x_reg;
    logic signed [DELTA_W-1:0] delta_y_reg;
    logic                      gesture_start_reg;
    logic [TIME_W-1:0]         stamp_reg;
    logic                      last_reg;

    logic signed [STEP_W-1:0]  step_x;
    logic signed [STEP_W-1:0]  step_y;
    logic signed [STEP_W-1:0]  scale_op;
    logic [15:0]               scale_eff;
    logic signed [STEP_W-1:0]  mul_a;
    logic signed [STEP_W-1:0]  mul_b;
    logic signed [MUL_W-1:0]   mul_p;
    logic [ROOT_W-1:0]         root;
    logic                      root_done;
    logic signed [WX_W-1:0]    whole_x;
    logic signed [WX_W-1:0]    whole_y;
    logic [TRAVEL_W:0]         travel_sum;
    logic [TIME_W-1:0]         elapsed;
    logic [CMP_W-1:0]          travel_cmp;
    logic [CMP_W-1:0]          slop_cmp;
    logic                      out_free;

    // Truncate toward zero by an arithmetic shift with a bias on negatives
    function automatic logic signed [WX_W-1:0] trunc_whole(input logic signed [WX_W-1:0] w);
        logic signed [WX_W-1:0] biased;
        biased = w[WX_W-1] ? (w + signed'(FRAC_MASK)) : w;
        return biased >>> FRAC_W;
    endfunction

    // Clamp to the signed delta range
    function automatic logic signed [DELTA_W-1:0] sat_delta(input logic signed [WX_W-1:0] w);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &w[WX_W-1:DELTA_W-1];
        hi_zeros = ~|w[WX_W-1:DELTA_W-1];
        if (hi_ones || hi_zeros)
        begin
            return w[DELTA_W-1:0];
        end
        return w[WX_W-1] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
    endfunction

    // Step from the previous position
    assign step_x    = signed'({1'b0, pos_x_reg}) - signed'({1'b0, prev_x_reg});
    assign step_y    = signed'({1'b0, pos_y_reg}) - signed'({1'b0, prev_y_reg});
    assign scale_eff = (inv_scale_reg == '0) ? UNITY_SCALE : inv_scale_reg;
    assign scale_op  = signed'({1'b0, scale_eff});

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_XX:
            begin
                mul_a = step_x;
                mul_b = step_x;
            end
            MUL_YY:
            begin
                mul_a = step_y;
                mul_b = step_y;
            end
            MUL_XS:
            begin
                mul_a = step_x;
                mul_b = scale_op;
            end
            MUL_YS:
            begin
                mul_a = step_y;
                mul_b = scale_op;
            end
            default:
            begin
                mul_a = step_x;
                mul_b = step_x;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    tprt_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (sumsq_reg),
        .root     (root),
        .done     (root_done)
    );

    assign whole_x    = trunc_whole(wx_reg);
    assign whole_y    = trunc_whole(wy_reg);
    assign travel_sum = {1'b0, travel_reg} + (TRAVEL_W + 1)'(root);
    assign elapsed    = time_reg - start_time_reg;
    assign travel_cmp = CMP_W'(travel_reg) << SCALE_FRAC_BITS;
    assign slop_cmp   = (CMP_W'({density_reg, 3'b000}) + CMP_W'({density_reg, 1'b0}))
                        << POS_FRAC_BITS;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_reg    <= INV_SCALE_RST;
            density_reg      <= DENSITY_RST;
            tap_max_time_reg <= TAP_MAX_TIME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INV_SCALE:    inv_scale_reg    <= cfg_data[15:0];
                CFG_DENSITY:      density_reg      <= cfg_data[15:0];
                CFG_TAP_MAX_TIME: tap_max_time_reg <= cfg_data[23:0];
                default:          ;
            endcase
        end
    end

    // Slide state: begin, commit and start flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slide_on_reg        <= 1'b0;
            start_flag_sent_reg <= 1'b0;
            prev_x_reg          <= '0;
            prev_y_reg          <= '0;
            carry_x_reg         <= '0;
            carry_y_reg         <= '0;
            start_time_reg      <= '0;
            travel_reg          <= '0;
        end
        else
        begin
            if (cmd.begin_slide)
            begin
                slide_on_reg        <= 1'b1;
                start_flag_sent_reg <= 1'b0;
                prev_x_reg          <= pos_x_reg;
                prev_y_reg          <= pos_y_reg;
                carry_x_reg         <= '0;
                carry_y_reg         <= '0;
                start_time_reg      <= time_reg;
                travel_reg          <= '0;
            end
            if (cmd.commit)
            begin
                prev_x_reg  <= pos_x_reg;
                prev_y_reg  <= pos_y_reg;
                carry_x_reg <= CARRY_W'(wx_reg - (whole_x <<< FRAC_W));
                carry_y_reg <= CARRY_W'(wy_reg - (whole_y <<< FRAC_W));
                travel_reg  <= travel_sum[TRAVEL_W] ? {TRAVEL_W{1'b1}}
                                                    : travel_sum[TRAVEL_W-1:0];
                if (req_type_reg == REQ_END)
                begin
                    slide_on_reg <= 1'b0;
                end
            end
            if (cmd.emit)
            begin
                start_flag_sent_reg <= 1'b1;
            end
        end
    end

    // Latch the request beat and run the arithmetic steps
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            pos_x_reg    <= pos_x;
            pos_y_reg    <= pos_y;
            time_reg     <= time_us;
        end
        if (cmd.prod_load)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.sum_first)
        begin
            sumsq_reg <= $unsigned(prod_reg);
        end
        else if (cmd.sum_add)
        begin
            sumsq_reg <= sumsq_reg + $unsigned(prod_reg);
        end
        if (cmd.wx_load)
        begin
            wx_reg <= WX_W'(prod_reg) + WX_W'(carry_x_reg);
        end
        if (cmd.wy_load)
        begin
            wy_reg <= WX_W'(prod_reg) + WX_W'(carry_y_reg);
        end
        if (cmd.commit)
        begin
            dx_reg      <= sat_delta(whole_x);
            dy_reg      <= sat_delta(whole_y);
            move_nz_reg <= (whole_x != '0) || (whole_y != '0);
        end
        if (cmd.test)
        begin
            tap_ok_reg <= (req_type_reg == REQ_END)
                          && (elapsed <= TIME_W'(tap_max_time_reg))
                          && (travel_cmp <= slop_cmp);
        end
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            action_reg        <= cmd.emit_action;
            delta_x_reg       <= (cmd.emit_action == ACT_MOVE) ? dx_reg : '0;
            delta_y_reg       <= (cmd.emit_action == ACT_MOVE) ? dy_reg : '0;
            gesture_start_reg <= !start_flag_sent_reg;
            stamp_reg         <= time_reg;
            last_reg          <= cmd.emit_last;
        end
    end

    assign sts.req_type  = req_type_reg;
    assign sts.slide_on  = slide_on_reg;
    assign sts.root_done = root_done;
    assign sts.move_nz   = move_nz_reg;
    assign sts.tap_ok    = tap_ok_reg;
    assign sts.out_free  = out_free;

    assign rsp_valid     = rsp_valid_reg;
    assign action        = action_reg;
    assign delta_x       = delta_x_reg;
    assign delta_y       = delta_y_reg;
    assign gesture_start = gesture_start_reg;
    assign stamp_us      = stamp_reg;
    assign last          = last_reg;

    // A result beat never overwrites one that is still held
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded while previous beat still stalled");

    // Commit only uses a finished root
    a_commit_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> root_done)
        else $error("commit before square root finished");

    // Begin restarts the slide cleanly
    a_begin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.begin_slide |=> (slide_on_reg && !start_flag_sent_reg && travel_reg == '0))
        else $error("begin did not restart the slide");

    // Travel only grows within a slide
    a_travel_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.begin_slide |=> (travel_reg >= $past(travel_reg)))
        else $error("travel decreased without a begin");

    // Carried remainders stay below one pixel
    a_carry_range: assert property (@(posedge clk) disable iff (!rst_n)
        (carry_x_reg != CARRY_MIN) && (carry_y_reg != CARRY_MIN))
        else $error("carried remainder reached a whole pixel");

endmodule
